[design/cfr_pkg.sv]
// Shared constants and types for the checksum frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfr_pkg;

   // Frame lengths in bytes, sync byte included
   localparam int SHORT_LEN = 10;
   localparam int LONG_LEN  = 32;

   // Index of the checksum byte for each mode
   localparam logic [7:0] SHORT_LAST = 8'(SHORT_LEN - 1);
   localparam logic [7:0] LONG_LAST  = 8'(LONG_LEN - 1);

   localparam logic [7:0] SYNC_BYTE = 8'h55;
   localparam logic [7:0] POS_HUNT  = 8'h00;
   localparam logic [7:0] POS_FIRST = 8'h01;

   // Frame bytes 1..8 hold the decoded fields
   localparam int FIELD_COUNT = 8;

   typedef struct packed {
      logic       frame_ok;
      logic       fields_valid;
      logic       left_stick_key;
      logic       right_stick_key;
      logic [3:0] dial_bits;
      logic [7:0] buttons;
      logic [7:0] stick_0;
      logic [7:0] stick_1;
      logic [7:0] stick_2;
      logic [7:0] stick_3;
      logic [7:0] stick_4;
      logic [7:0] stick_5;
   } result_type;

endpackage

`default_nettype wire

[design/cfr_frame_parser.sv]
// Frame parser: mode register, byte position, running sum, field bytes and
// result decode for the checksum frame receiver. Depends on cfr_pkg.
`default_nettype none

module cfr_frame_parser
   import cfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,
   input  wire logic       take,
   input  wire logic [7:0] rx_byte,
   output logic            at_last,
   output logic            result_fire,
   output result_type      result
);

   logic       long_frames_ff;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] field_ff [FIELD_COUNT];
   logic [7:0] last;
   logic       capture;
   logic       ok;
   logic       valid;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         long_frames_ff <= 1'b0;
      end else if (csr_we) begin
         long_frames_ff <= csr_wdata;
      end
   end

   assign last    = long_frames_ff ? LONG_LAST : SHORT_LAST;
   assign at_last = (pos_ff != POS_HUNT) && (pos_ff == last);

   // Advance position and sum for one transaction
   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      capture = 1'b0;
      if (take) begin
         if (pos_ff == POS_HUNT) begin
            if (rx_byte == SYNC_BYTE) begin
               pos_in = POS_FIRST;
               sum_in = rx_byte;
            end
         end else if (pos_ff < last) begin
            capture = 1'b1;
            sum_in  = sum_ff + rx_byte;
            pos_in  = pos_ff + 8'd1;
         end else begin
            // Checksum byte, or position beyond a shortened frame: hunt again
            pos_in = POS_HUNT;
            sum_in = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= 8'h00;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Store frame bytes 1..8, each in its own lane
   always_ff @(posedge clock) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
         if (capture && (pos_ff == 8'(i + 1))) begin
            field_ff[i] <= rx_byte;
         end
      end
   end

   // Decode the result at the checksum byte
   assign result_fire = take && at_last;
   assign ok          = (rx_byte == sum_ff);
   assign valid       = ok && !long_frames_ff;

   always_comb begin
      result              = '0;
      result.frame_ok     = ok;
      result.fields_valid = valid;
      if (valid) begin
         result.left_stick_key  = field_ff[0][5];
         result.right_stick_key = field_ff[0][4];
         result.dial_bits       = field_ff[0][3:0];
         result.buttons         = field_ff[1];
         result.stick_0         = field_ff[2];
         result.stick_1         = field_ff[3];
         result.stick_2         = field_ff[4];
         result.stick_3         = field_ff[5];
         result.stick_4         = field_ff[6];
         result.stick_5         = field_ff[7];
      end
   end

`ifndef ASSERT_OFF
   a_hunt_after_result: assert property (@(posedge clock) disable iff (reset)
      result_fire |=> (pos_ff == POS_HUNT) && (sum_ff == 8'h00))
      else $error("parser did not return to hunting after a result");

   a_drop_non_sync: assert property (@(posedge clock) disable iff (reset)
      (take && (pos_ff == POS_HUNT) && (rx_byte != SYNC_BYTE)) |=> (pos_ff == POS_HUNT))
      else $error("non-sync byte left the hunt");

   a_sync_starts_frame: assert property (@(posedge clock) disable iff (reset)
      (take && (pos_ff == POS_HUNT) && (rx_byte == SYNC_BYTE))
         |=> (pos_ff == POS_FIRST) && (sum_ff == SYNC_BYTE))
      else $error("sync byte did not open a frame");

   a_fields_short_only: assert property (@(posedge clock) disable iff (reset)
      result_fire && result.fields_valid |-> !long_frames_ff && result.frame_ok)
      else $error("fields flagged valid outside a good short frame");
`endif

endmodule

`default_nettype wire

[design/cfr_result_reg.sv]
// Result register for the checksum frame receiver's output channel.
// Depends on cfr_pkg for the result type.
`default_nettype none

module cfr_result_reg
   import cfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire result_type  load_data,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output result_type       rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Load a new result, or drop the held one once it is taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && (data_ff == $past(load_data)))
      else $error("loaded result not presented");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.fields_valid |->
         (data_ff.buttons == 8'h00) && (data_ff.dial_bits == 4'h0) &&
         (data_ff.stick_0 == 8'h00) && (data_ff.stick_5 == 8'h00))
      else $error("fields not cleared on an invalid frame");
`endif

endmodule

`default_nettype wire

[design/checksum_frame_receiver.sv]
// Channel  Ports                     Direction  Moves
// req      req_valid/req_stall       in         one received byte
// rsp      rsp_valid/rsp_stall       out        one frame result
// csr      csr_we/csr_wdata          in         long_frames mode bit
//
// One byte per cycle unless req_stall holds it. A frame result appears on
// rsp in the cycle after its checksum byte is taken.
// Synchronous active-high reset hunts for sync, clears the sum and selects
// short frames. req_stall rises only when the parser sits at a checksum
// byte while the result register holds an untaken result; other bytes keep
// flowing under a stalled rsp. Depends on cfr_pkg, cfr_frame_parser and
// cfr_result_reg.
`default_nettype none

module checksum_frame_receiver
   import cfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_frame_ok,
   output logic            rsp_fields_valid,
   output logic            rsp_left_stick_key,
   output logic            rsp_right_stick_key,
   output logic [3:0]      rsp_dial_bits,
   output logic [7:0]      rsp_buttons,
   output logic [7:0]      rsp_stick_0,
   output logic [7:0]      rsp_stick_1,
   output logic [7:0]      rsp_stick_2,
   output logic [7:0]      rsp_stick_3,
   output logic [7:0]      rsp_stick_4,
   output logic [7:0]      rsp_stick_5
);

   logic       at_last;
   logic       take;
   logic       result_fire;
   result_type result;
   result_type rsp_data;

   // Hold the byte only when its result has nowhere to go
   assign req_stall = at_last && rsp_valid && rsp_stall;
   assign take      = req_valid && !req_stall;

   cfr_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .take        (take),
      .rx_byte     (req_rx_byte),
      .at_last     (at_last),
      .result_fire (result_fire),
      .result      (result)
   );

   cfr_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (result_fire),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_frame_ok        = rsp_data.frame_ok;
   assign rsp_fields_valid    = rsp_data.fields_valid;
   assign rsp_left_stick_key  = rsp_data.left_stick_key;
   assign rsp_right_stick_key = rsp_data.right_stick_key;
   assign rsp_dial_bits       = rsp_data.dial_bits;
   assign rsp_buttons         = rsp_data.buttons;
   assign rsp_stick_0         = rsp_data.stick_0;
   assign rsp_stick_1         = rsp_data.stick_1;
   assign rsp_stick_2         = rsp_data.stick_2;
   assign rsp_stick_3         = rsp_data.stick_3;
   assign rsp_stick_4         = rsp_data.stick_4;
   assign rsp_stick_5         = rsp_data.stick_5;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for checksum_frame_receiver: byte stream in, frame results out.
// Predicts each result from its own parser state and compares it field by field.
// Depends on cfr_pkg and the checksum_frame_receiver RTL.
`default_nettype none

module tb_top;
   import cfr_pkg::*;

   localparam bit MODE_SHORT     = 1'b0;
   localparam bit MODE_LONG      = 1'b1;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP      = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_wdata = 1'b0;
   logic       req_valid = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_frame_ok;
   logic       rsp_fields_valid;
   logic       rsp_left_stick_key;
   logic       rsp_right_stick_key;
   logic [3:0] rsp_dial_bits;
   logic [7:0] rsp_buttons;
   logic [7:0] rsp_stick_0;
   logic [7:0] rsp_stick_1;
   logic [7:0] rsp_stick_2;
   logic [7:0] rsp_stick_3;
   logic [7:0] rsp_stick_4;
   logic [7:0] rsp_stick_5;

   // Parser state as the bench sees it
   bit         long_mode = MODE_SHORT;
   logic [7:0] frame_pos = POS_HUNT;
   logic [7:0] frame_sum = 8'h00;
   logic [7:0] frame_fields [FIELD_COUNT];

   result_type expected_frames [$];

   // Idle and pressure controls
   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;
   bit quiet_tail  = 1'b0;
   int hold_req    = 0;

   int bytes_taken    = 0;
   int bytes_used     = 0;
   int results_seen   = 0;
   int ok_seen        = 0;
   int fields_seen    = 0;
   int mode_writes    = 0;
   int mismatch_count = 0;

   checksum_frame_receiver dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_fields_valid    (rsp_fields_valid),
      .rsp_left_stick_key  (rsp_left_stick_key),
      .rsp_right_stick_key (rsp_right_stick_key),
      .rsp_dial_bits       (rsp_dial_bits),
      .rsp_buttons         (rsp_buttons),
      .rsp_stick_0         (rsp_stick_0),
      .rsp_stick_1         (rsp_stick_1),
      .rsp_stick_2         (rsp_stick_2),
      .rsp_stick_3         (rsp_stick_3),
      .rsp_stick_4         (rsp_stick_4),
      .rsp_stick_5         (rsp_stick_5)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] last_index();
      return long_mode ? LONG_LAST : SHORT_LAST;
   endfunction

   // Advance the parser by one byte; return 1 when the byte closes a frame
   function automatic bit frame_step(input logic [7:0] b, output result_type r);
      logic [7:0] last;
      last = last_index();
      r = '0;
      if (frame_pos == POS_HUNT) begin
         if (b == SYNC_BYTE) begin
            frame_sum = b;
            frame_pos = POS_FIRST;
         end
         return 1'b0;
      end
      if (frame_pos < last) begin
         if (frame_pos <= 8'(FIELD_COUNT))
            frame_fields[3'(frame_pos - 8'd1)] = b;
         frame_sum = frame_sum + b;
         frame_pos = frame_pos + 8'd1;
         return 1'b0;
      end
      // Mode shrank under a frame in progress: drop the byte and hunt
      if (frame_pos > last) begin
         frame_pos = POS_HUNT;
         frame_sum = 8'h00;
         return 1'b0;
      end
      r.frame_ok     = (b == frame_sum);
      r.fields_valid = r.frame_ok && !long_mode;
      if (r.fields_valid) begin
         r.left_stick_key  = frame_fields[0][5];
         r.right_stick_key = frame_fields[0][4];
         r.dial_bits       = frame_fields[0][3:0];
         r.buttons         = frame_fields[1];
         r.stick_0         = frame_fields[2];
         r.stick_1         = frame_fields[3];
         r.stick_2         = frame_fields[4];
         r.stick_3         = frame_fields[5];
         r.stick_4         = frame_fields[6];
         r.stick_5         = frame_fields[7];
      end
      frame_pos = POS_HUNT;
      frame_sum = 8'h00;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
   endtask

   // Offer one byte, hold it until taken, then update the prediction
   task automatic send_byte(input logic [7:0] b);
      result_type r;
      bit         hunting;
      if (req_gaps_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hunting = (frame_pos == POS_HUNT);
      if (frame_step(b, r))
         expected_frames.push_back(r);
      if (!hunting || b == SYNC_BYTE)
         bytes_used++;
      bytes_taken++;
   endtask

   // Fill out the frame in progress and close it with its checksum byte
   task automatic finish_frame(input bit corrupt, input int fill);
      while (frame_pos != POS_HUNT && frame_pos != last_index())
         send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
      if (frame_pos != POS_HUNT)
         send_byte(corrupt ? frame_sum ^ 8'($urandom_range(1, 255)) : frame_sum);
   endtask

   task automatic send_frame(input bit corrupt, input int fill);
      send_byte(SYNC_BYTE);
      finish_frame(corrupt, fill);
   endtask

   // Drop valid and wait for every pending result plus the block's latency
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input bit m);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
      long_mode = m;
      mode_writes++;
   endtask

   // Random pick: mostly clean frames, some bad sums, noise, cut frames, mode flips
   task automatic random_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 78)
         send_frame(1'b0, -1);
      else if (pick < 88)
         send_frame(1'b1, -1);
      else if (pick < 93)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      else if (pick < 97) begin
         send_byte(SYNC_BYTE);
         repeat ($urandom_range(1, 30)) send_byte(8'($urandom));
      end else
         set_mode(!long_mode);
   endtask

   task automatic test_directed_short();
      // Non-sync bytes while hunting are dropped
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_BYTE - 8'd1);
      send_byte(SYNC_BYTE + 8'd1);
      send_frame(1'b0, 8'hFF);
      send_frame(1'b1, 8'h00);
      send_frame(1'b0, 8'h00);
      wait_drained();
   endtask

   task automatic test_long_mode();
      set_mode(MODE_LONG);
      send_frame(1'b0, 8'hFF);
      send_frame(1'b0, -1);
      send_frame(1'b1, -1);
      set_mode(MODE_SHORT);
   endtask

   task automatic test_mode_switch();
      // Long frame past the short checksum index, then shrink: drop and hunt
      set_mode(MODE_LONG);
      send_byte(SYNC_BYTE);
      repeat (14) send_byte(8'($urandom));
      set_mode(MODE_SHORT);
      send_byte(8'hA5);
      send_frame(1'b0, -1);
      // Short frame grown into a long one
      send_byte(SYNC_BYTE);
      repeat (4) send_byte(8'($urandom));
      set_mode(MODE_LONG);
      finish_frame(1'b0, -1);
      // Switch exactly at the short checksum index
      send_byte(SYNC_BYTE);
      repeat (8) send_byte(8'($urandom));
      set_mode(MODE_SHORT);
      finish_frame(1'b0, -1);
      wait_drained();
   endtask

   task automatic test_random_frames(input int item_goal);
      int goal;
      goal = bytes_used + item_goal;
      while (bytes_used < goal) begin
         set_mode($urandom_range(0, 2) == 0 ? MODE_LONG : MODE_SHORT);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(4, 20)) random_sequence();
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Hold off the receiver long enough that the block stalls its input
   task automatic test_backpressure();
      set_mode(MODE_SHORT);
      req_gaps_on = 1'b0;
      hold_req    = HOLD_CYCLES;
      repeat (12) send_frame(1'b0, -1);
      wait_drained();
      req_gaps_on = 1'b1;
   endtask

   // Pause the sender until every result is in, then resume
   task automatic test_drain_pause();
      repeat (3) begin
         repeat (3) send_frame(1'b0, -1);
         wait_drained();
      end
   endtask

   task automatic test_final_burst(input int item_goal);
      int goal;
      quiet_tail = 1'b1;
      goal = bytes_used + item_goal;
      while (bytes_used < goal) random_sequence();
      wait_drained();
   endtask

   // Receiver stall: random bursts, plus a long hold on request
   initial begin : rsp_stall_driver
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (burst == 0 && hold_req > 0) begin
            burst    = hold_req;
            hold_req = 0;
         end else if (burst == 0 && rsp_gaps_on && !quiet_tail
                      && $urandom_range(0, 9) == 0)
            burst = $urandom_range(1, 16);
         if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // Compare each result transaction with the oldest expectation
   initial begin : result_checker
      result_type got;
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_frame_ok, rsp_fields_valid, rsp_left_stick_key,
                   rsp_right_stick_key, rsp_dial_bits, rsp_buttons, rsp_stick_0,
                   rsp_stick_1, rsp_stick_2, rsp_stick_3, rsp_stick_4, rsp_stick_5};
            if (expected_frames.size() == 0)
               report_mismatch($sformatf("result with none pending: 0x%0h", got));
            else begin
               want = expected_frames.pop_front();
               check_field("frame_ok", 8'(got.frame_ok), 8'(want.frame_ok));
               check_field("fields_valid", 8'(got.fields_valid),
                           8'(want.fields_valid));
               check_field("left_stick_key", 8'(got.left_stick_key),
                           8'(want.left_stick_key));
               check_field("right_stick_key", 8'(got.right_stick_key),
                           8'(want.right_stick_key));
               check_field("dial_bits", 8'(got.dial_bits), 8'(want.dial_bits));
               check_field("buttons", got.buttons, want.buttons);
               check_field("stick_0", got.stick_0, want.stick_0);
               check_field("stick_1", got.stick_1, want.stick_1);
               check_field("stick_2", got.stick_2, want.stick_2);
               check_field("stick_3", got.stick_3, want.stick_3);
               check_field("stick_4", got.stick_4, want.stick_4);
               check_field("stick_5", got.stick_5, want.stick_5);
               if (want.frame_ok) ok_seen++;
               if (want.fields_valid) fields_seen++;
            end
            results_seen++;
         end
      end
   end

   // End the run when no transaction moves for too long
   initial begin : watchdog
      int stuck;
      stuck = 0;
      wait (!reset);
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck = 0;
         else
            stuck++;
      end
      $display("TIMEOUT: no transaction for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, expected_frames.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : main
      foreach (frame_fields[i]) frame_fields[i] = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_short();
      test_long_mode();
      test_mode_switch();
      test_random_frames(1100);
      test_backpressure();
      test_drain_pause();
      test_final_burst(150);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes (%0d inside frames), %0d mode writes, short and long frames,",
               bytes_taken, bytes_used, mode_writes);
      $display("mid-frame mode changes and a long receiver hold; %0d results, %0d good,",
               results_seen, ok_seen);
      $display("%0d decoded", fields_seen);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
